// ===== hw/rtl/srpc_pkg.sv =====
// shared codes, command types and fixed constants for the pileup counter
// no dependencies; imported by every module of the block
package srpc_pkg;

   // item kinds
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   // result status codes
   localparam logic [2:0] ST_COUNTED   = 3'd0;
   localparam logic [2:0] ST_REACHED   = 3'd1;
   localparam logic [2:0] ST_SATURATED = 3'd2;
   localparam logic [2:0] ST_REJECTED  = 3'd3;
   localparam logic [2:0] ST_LOADED    = 3'd4;
   localparam logic [2:0] ST_QUERY     = 3'd5;

   localparam logic [10:0] READ_LEN_RESET = 11'd20;
   localparam logic [7:0]  COUNT_MAX      = 8'd255;
   localparam int          QUEUE_DEPTH    = 2;

   // what the back end does with a command
   typedef enum logic [1:0] {
      OP_REPLY,
      OP_QUERY,
      OP_COUNT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] status;
   } cmd_ctl_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_EXEC
   } back_state_type;

endpackage

// ===== hw/rtl/srpc_queue.sv =====
// small command fifo between the front and back ends
// depends on srpc_pkg for the queue depth
module srpc_queue
   import srpc_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0] slot_ff [0:QUEUE_DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   cnt_ff, cnt_in;

   assign full      = (cnt_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/srpc_front.sv =====
// front end: accepts words, owns the length table and read length register,
// classifies each word into a command for the back end; uses srpc_pkg
module srpc_front
   import srpc_pkg::*;
#(
   parameter int NUM_SEQS = 4,
   parameter int POS_BITS = 14
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_kind,
   input  logic [7:0]              req_seq_index,
   input  logic [31:0]             req_position,
   input  logic                    req_reverse_strand,
   input  logic [31:0]             req_seq_length,
   input  logic                    csr_we,
   input  logic [10:0]             csr_wdata,
   input  logic                    hold,
   input  logic                    q_full,
   output logic                    push,
   output cmd_ctl_type             push_ctl,
   output logic [(NUM_SEQS > 1 ? $clog2(NUM_SEQS) : 1)+POS_BITS:0] push_addr
);

   localparam int SEQ_BITS = (NUM_SEQS > 1) ? $clog2(NUM_SEQS) : 1;
   localparam int LEN_W    = POS_BITS + 1;
   localparam logic [LEN_W-1:0]    CAP      = {1'b1, {POS_BITS{1'b0}}};
   localparam logic [7:0]          NSEQ8    = 8'(NUM_SEQS);
   localparam logic [SEQ_BITS-1:0] LAST_SEQ = SEQ_BITS'(NUM_SEQS - 1);

   logic [LEN_W-1:0] len_mem [0:NUM_SEQS-1];

   logic                clr_ff, clr_in;
   logic [SEQ_BITS-1:0] clr_idx_ff, clr_idx_in;
   logic                a_valid_ff, a_valid_in;
   logic [1:0]          kind_ff;
   logic [7:0]          seq_ff;
   logic [31:0]         pos_ff;
   logic                rev_ff;
   logic [LEN_W-1:0]    len_rd_ff;
   logic [10:0]         read_len_ff;

   logic                accept;
   logic                req_seq_ok;
   logic [SEQ_BITS-1:0] req_seq_m1;
   logic [SEQ_BITS-1:0] rd_idx;
   logic [LEN_W-1:0]    len_clamped;

   logic                seq_ok_a;
   logic [SEQ_BITS-1:0] seq_m1_a;
   logic [10:0]         rl_eff;
   logic [32:0]         rev_end;
   logic [32:0]         len33;
   logic [31:0]         fwd_off;
   logic [POS_BITS-1:0] rev_off;
   logic [POS_BITS-1:0] off;
   logic                read_fits;

   assign busy   = clr_ff || hold || (a_valid_ff && q_full);
   assign accept = start && !busy;
   assign push   = a_valid_ff && !q_full;

   assign req_seq_ok  = (req_seq_index != 8'd0) && (req_seq_index <= NSEQ8);
   assign req_seq_m1  = SEQ_BITS'(req_seq_index - 8'd1);
   assign rd_idx      = req_seq_ok ? req_seq_m1 : '0;
   assign len_clamped = (req_seq_length > 32'(CAP)) ? CAP : req_seq_length[LEN_W-1:0];

   // length table clear sweep after reset, and the staged word valid flag
   always_comb begin
      clr_in     = clr_ff;
      clr_idx_in = clr_idx_ff;
      if (clr_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == LAST_SEQ) begin
            clr_in = 1'b0;
         end
      end
      a_valid_in = a_valid_ff;
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (push) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_idx_ff  <= '0;
         a_valid_ff  <= 1'b0;
         read_len_ff <= READ_LEN_RESET;
      end else begin
         clr_ff     <= clr_in;
         clr_idx_ff <= clr_idx_in;
         a_valid_ff <= a_valid_in;
         if (csr_we) begin
            read_len_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
         seq_ff  <= req_seq_index;
         pos_ff  <= req_position;
         rev_ff  <= req_reverse_strand;
      end
   end

   // length table: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (clr_ff) begin
         len_mem[clr_idx_ff] <= '0;
      end else if (accept && req_seq_ok && req_kind == KIND_LOAD) begin
         len_mem[req_seq_m1] <= len_clamped;
      end
      if (accept) begin
         len_rd_ff <= len_mem[rd_idx];
      end
   end

   // classify the staged word
   assign seq_ok_a = (seq_ff != 8'd0) && (seq_ff <= NSEQ8);
   assign seq_m1_a = SEQ_BITS'(seq_ff - 8'd1);
   assign rl_eff   = (read_len_ff == 11'd0) ? 11'd1 : read_len_ff;
   assign rev_end  = {1'b0, pos_ff} + 33'(rl_eff) - 33'd1;
   assign len33    = 33'(len_rd_ff);
   assign fwd_off  = pos_ff - 32'd1;
   assign rev_off  = POS_BITS'(rev_end - 33'd1);
   assign read_fits = rev_ff ? (rev_end <= len33) : ({1'b0, pos_ff} <= len33);

   always_comb begin
      push_ctl = '{op: OP_REPLY, status: ST_REJECTED};
      off      = '0;
      if (seq_ok_a) begin
         case (kind_ff)
            KIND_LOAD: begin
               push_ctl.status = ST_LOADED;
            end
            KIND_QUERY: begin
               if (pos_ff[31:POS_BITS] == '0) begin
                  push_ctl = '{op: OP_QUERY, status: ST_QUERY};
                  off      = pos_ff[POS_BITS-1:0];
               end
            end
            KIND_READ: begin
               if (pos_ff != 32'd0 && read_fits) begin
                  push_ctl = '{op: OP_COUNT, status: ST_COUNTED};
                  off      = rev_ff ? rev_off : fwd_off[POS_BITS-1:0];
               end
            end
            default: begin
               push_ctl = '{op: OP_REPLY, status: ST_REJECTED};
            end
         endcase
      end
   end

   assign push_addr = {seq_m1_a, rev_ff, off};

endmodule

// ===== hw/rtl/srpc_back.sv =====
// back end: owns the counter memory and clipped total, runs the clear sweep,
// carries out queued commands and drives the result word; uses srpc_pkg
module srpc_back
   import srpc_pkg::*;
#(
   parameter int ADDR_W = 17,
   parameter int DEPTH  = 131072
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  cmd_ctl_type       head_ctl,
   input  logic [ADDR_W-1:0] head_addr,
   output logic              pop,
   output logic              clearing,
   output logic              rsp_strobe,
   output logic [2:0]        rsp_status,
   output logic [7:0]        rsp_count_value,
   output logic [31:0]       rsp_clipped_total
);

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   logic [7:0] count_mem [0:DEPTH-1];

   back_state_type    state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   op_type            cmd_op_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [7:0]        rd_data_ff;
   logic [31:0]       clip_ff, clip_in;
   logic              strobe_ff, strobe_in;
   logic [2:0]        status_ff, status_in;
   logic [7:0]        value_ff, value_in;
   logic [31:0]       total_ff, total_in;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata;
   logic [7:0]        bumped;

   assign bumped    = rd_data_ff + 8'd1;
   assign mem_waddr = clearing ? clr_addr_ff : addr_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR: begin
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (head_valid && head_ctl.op != OP_REPLY) begin
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_CLEAR;
         end
      endcase
   end

   always_comb begin
      pop         = 1'b0;
      clearing    = 1'b0;
      mem_we      = 1'b0;
      mem_wdata   = '0;
      clr_addr_in = clr_addr_ff;
      clip_in     = clip_ff;
      strobe_in   = 1'b0;
      status_in   = status_ff;
      value_in    = value_ff;
      total_in    = total_ff;
      case (state_ff)
         BK_CLEAR: begin
            clearing    = 1'b1;
            mem_we      = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         BK_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               if (head_ctl.op == OP_REPLY) begin
                  strobe_in = 1'b1;
                  status_in = head_ctl.status;
                  value_in  = 8'd0;
                  total_in  = clip_ff;
               end
            end
         end
         BK_EXEC: begin
            strobe_in = 1'b1;
            total_in  = clip_ff;
            if (cmd_op_ff == OP_QUERY) begin
               status_in = ST_QUERY;
               value_in  = rd_data_ff;
            end else if (rd_data_ff == COUNT_MAX) begin
               status_in = ST_SATURATED;
               value_in  = COUNT_MAX;
            end else begin
               mem_we    = 1'b1;
               mem_wdata = bumped;
               value_in  = bumped;
               if (bumped == COUNT_MAX) begin
                  status_in = ST_REACHED;
                  if (clip_ff != '1) begin
                     clip_in = clip_ff + 32'd1;
                  end
                  total_in = clip_in;
               end else begin
                  status_in = ST_COUNTED;
               end
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_CLEAR;
         clr_addr_ff <= '0;
         clip_ff     <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         clip_ff     <= clip_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      value_ff  <= value_in;
      total_ff  <= total_in;
      if (pop) begin
         cmd_op_ff <= head_ctl.op;
         addr_ff   <= head_addr;
      end
   end

   // counter memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_mem[mem_waddr] <= mem_wdata;
      end
      if (pop) begin
         rd_data_ff <= count_mem[head_addr];
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_count_value   = value_ff;
   assign rsp_clipped_total = total_ff;

`ifndef ASSERT_OFF
   a_exec_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_EXEC |=> state_ff == BK_IDLE)
      else $error("back end stayed in exec");

   a_quiet_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !strobe_ff)
      else $error("result word during clear sweep");

   a_clip_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> clip_ff >= $past(clip_ff))
      else $error("clipped total went down");

   a_reached_value: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && status_ff == ST_REACHED) |-> value_ff == COUNT_MAX)
      else $error("reached status without full counter");
`endif

endmodule

// ===== hw/rtl/stranded_read_pileup_counter.sv =====
// top level of the stranded read pileup counter
// depends on srpc_pkg, srpc_front, srpc_queue and srpc_back
// result path: a rejected or length-load word passes the staging registers, the queue
//   and the result registers; a count or query word also passes the counter memory read
// throughput: one word per cycle into the front end while busy is low; the back
//   end retires one reply per cycle; a count reads, then writes the counter memory
// reset: synchronous; busy stays high while the counter memory, NUM_SEQS*2*2^POS_BITS
//   words (131072 at the defaults), is swept to zero
// results carry a one-cycle strobe; the receiver cannot stall
module stranded_read_pileup_counter
   import srpc_pkg::*;
#(
   parameter int NUM_SEQS = 4,
   parameter int POS_BITS = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_seq_index,
   input  logic [31:0] req_position,
   input  logic        req_reverse_strand,
   input  logic [31:0] req_seq_length,
   input  logic        csr_we,
   input  logic [10:0] csr_wdata,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_count_value,
   output logic [31:0] rsp_clipped_total
);

   // address = {sequence - 1, strand, position offset}
   localparam int SEQ_BITS = (NUM_SEQS > 1) ? $clog2(NUM_SEQS) : 1;
   localparam int ADDR_W   = SEQ_BITS + 1 + POS_BITS;
   localparam int DEPTH    = NUM_SEQS * 2 * (2 ** POS_BITS);
   localparam int CMD_W    = $bits(cmd_ctl_type) + ADDR_W;

   // front to queue
   logic              push;
   cmd_ctl_type       push_ctl;
   logic [ADDR_W-1:0] push_addr;
   logic              q_full;

   // queue to back
   logic [CMD_W-1:0]  head_data;
   logic              head_valid;
   cmd_ctl_type       head_ctl;
   logic [ADDR_W-1:0] head_addr;
   logic              pop;

   // back end sweep holds off new words
   logic              back_clearing;

   assign head_ctl  = cmd_ctl_type'(head_data[CMD_W-1:ADDR_W]);
   assign head_addr = head_data[ADDR_W-1:0];

   // accept, length table, read length register and classification
   srpc_front #(
      .NUM_SEQS (NUM_SEQS),
      .POS_BITS (POS_BITS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_seq_index      (req_seq_index),
      .req_position       (req_position),
      .req_reverse_strand (req_reverse_strand),
      .req_seq_length     (req_seq_length),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .hold               (back_clearing),
      .q_full             (q_full),
      .push               (push),
      .push_ctl           (push_ctl),
      .push_addr          (push_addr)
   );

   // decouples classification from the memory read-modify-write
   srpc_queue #(
      .WIDTH (CMD_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_ctl, push_addr}),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (head_data),
      .not_empty (head_valid)
   );

   // counter memory, saturation and clipped total
   srpc_back #(
      .ADDR_W (ADDR_W),
      .DEPTH  (DEPTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_ctl          (head_ctl),
      .head_addr         (head_addr),
      .pop               (pop),
      .clearing          (back_clearing),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_count_value   (rsp_count_value),
      .rsp_clipped_total (rsp_clipped_total)
   );

endmodule
